/* src/ffba_pkg.sv */
// Shared constants and opcode codes for the first-fit byte allocator.
`default_nettype none
package ffba_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int ADDR_W     = 8;
    localparam int MAP_W      = 9;
    localparam int DATA_W     = 8;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_REALLOC = 3'd2;
    localparam logic [OP_W-1:0] OP_READ    = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;

endpackage
`default_nettype wire

/* src/ffba_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/first_fit_byte_allocator_core.sv */
// Top level of the first-fit byte allocator: sequencer around status map and pool RAMs.
//
// Usage
//   Request channel (i_in_valid/o_in_ready) carries opcode, size, address and
//   write data; the result channel (o_out_valid/i_out_ready) returns ok,
//   block start and read data, exactly one result per request.
//   Configuration channel (i_cfg_valid/o_cfg_ready) writes pool_size; write it
//   only while the block is idle. It is always ready.
// Operation
//   One request is worked on at a time. Free reads the block's head entry
//   and then clears its run of status entries; allocate walks the status map
//   one entry per cycle and then marks size entries; reallocate adds a
//   release, the search, a mark and a copy that reads and then writes each byte.
// Reset
//   After reset the status map is swept to zero, one entry a cycle, over all 256
//   entries; no request is taken during the sweep. pool_size resets to 256.
// Stall
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its result waits until the register drains.
`default_nettype none
module first_fit_byte_allocator_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [8:0] i_cfg_pool_size,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_opcode,
    input  wire logic [8:0] i_size,
    input  wire logic [7:0] i_address,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_ok,
    output logic [7:0]      o_block_start,
    output logic [7:0]      o_read_data
);

    localparam int AW = ffba_pkg::ADDR_W;
    localparam int MW = ffba_pkg::MAP_W;
    localparam int DW = ffba_pkg::DATA_W;
    localparam logic [MW-1:0] DEPTH_V = MW'(ffba_pkg::POOL_DEPTH);
    localparam logic [MW-1:0] LAST_V  = MW'(ffba_pkg::POOL_DEPTH - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HEAD = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_WRUN = 4'd4;
    localparam logic [3:0] S_CPRD = 4'd5;
    localparam logic [3:0] S_CPWR = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_RES  = 4'd8;

    // what follows a status-map write run
    localparam logic [1:0] AFT_OK   = 2'd0;
    localparam logic [1:0] AFT_SRCH = 2'd1;
    localparam logic [1:0] AFT_COPY = 2'd2;
    localparam logic [1:0] AFT_FAIL = 2'd3;

    logic [3:0]      r_state, n_state;
    logic [8:0]      r_pool_size;
    logic [2:0]      r_op, n_op;
    logic [MW-1:0]   r_size, n_size;
    logic [AW-1:0]   r_addr, n_addr;
    logic [MW-1:0]   r_old, n_old;
    logic [MW-1:0]   r_idx, n_idx;
    logic            r_pv, n_pv;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic [MW-1:0]   r_run, n_run;
    logic [AW-1:0]   r_wstart, n_wstart;
    logic [MW-1:0]   r_wlen, n_wlen;
    logic            r_wzero, n_wzero;
    logic [1:0]      r_after, n_after;
    logic [AW-1:0]   r_new, n_new;
    logic            r_desc, n_desc;
    logic [MW-1:0]   r_rem, n_rem;
    logic            r_res_ok, n_res_ok;
    logic [AW-1:0]   r_res_start, n_res_start;
    logic [DW-1:0]   r_res_rdata, n_res_rdata;
    logic            r_out_valid;
    logic            r_ok;
    logic [AW-1:0]   r_start;
    logic [DW-1:0]   r_rdata;

    logic            st_we;
    logic [AW-1:0]   st_waddr, st_raddr;
    logic [MW-1:0]   st_wdata, st_rdata;
    logic            pl_we;
    logic [AW-1:0]   pl_waddr, pl_raddr;
    logic [DW-1:0]   pl_wdata, pl_rdata;

    logic [MW-1:0]   eff_n;
    logic            in_pool;
    logic            in_acc;
    logic [MW-1:0]   run_n;
    logic [MW-1:0]   wsum;
    logic            wlast;
    logic [MW-1:0]   room;
    logic [MW-1:0]   cnt;

    ffba_ram #(.WIDTH(MW), .DEPTH(ffba_pkg::POOL_DEPTH)) u_status (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    ffba_ram #(.WIDTH(DW), .DEPTH(ffba_pkg::POOL_DEPTH)) u_pool (
        .i_clk  (i_clk),
        .i_we   (pl_we),
        .i_waddr(pl_waddr),
        .i_wdata(pl_wdata),
        .i_raddr(pl_raddr),
        .o_rdata(pl_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_block_start = r_start;
    assign o_read_data   = r_rdata;

    assign eff_n   = (r_pool_size > DEPTH_V) ? DEPTH_V : r_pool_size;
    assign in_pool = ({1'b0, i_address} < eff_n);
    assign run_n   = (st_rdata == '0) ? (r_run + 1'b1) : '0;
    // sum is r_wstart plus progress, counted in r_idx during a write run
    assign wsum    = {1'b0, r_wstart} + r_idx;
    assign wlast   = ((r_idx + 1'b1) == r_wlen) || (wsum == LAST_V);
    assign room    = DEPTH_V - {1'b0, r_addr};

    always_comb begin
        cnt = (r_old < r_size) ? r_old : r_size;
        if (cnt > room) begin
            cnt = room;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_old       = r_old;
        n_idx       = r_idx;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_run       = r_run;
        n_wstart    = r_wstart;
        n_wlen      = r_wlen;
        n_wzero     = r_wzero;
        n_after     = r_after;
        n_new       = r_new;
        n_desc      = r_desc;
        n_rem       = r_rem;
        n_res_ok    = r_res_ok;
        n_res_start = r_res_start;
        n_res_rdata = r_res_rdata;
        st_we       = 1'b0;
        st_waddr    = r_idx[AW-1:0];
        st_wdata    = '0;
        st_raddr    = r_idx[AW-1:0];
        pl_we       = 1'b0;
        pl_waddr    = i_address;
        pl_wdata    = i_write_data;
        pl_raddr    = i_address;

        unique case (r_state)
            S_CLR: begin
                st_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_V) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                st_raddr    = i_address;
                n_res_ok    = 1'b0;
                n_res_start = '0;
                n_res_rdata = '0;
                if (in_acc) begin
                    n_op    = i_opcode;
                    n_size  = i_size;
                    n_addr  = i_address;
                    n_idx   = '0;
                    n_run   = '0;
                    n_state = S_RES;
                    case (i_opcode) inside
                        ffba_pkg::OP_ALLOC: begin
                            if (i_size != '0 && i_size <= eff_n) begin
                                n_state = S_SRCH;
                            end
                        end
                        ffba_pkg::OP_FREE, ffba_pkg::OP_REALLOC: begin
                            if (in_pool && !(i_opcode == ffba_pkg::OP_REALLOC
                                             && i_size == '0)) begin
                                n_state = S_HEAD;
                            end
                        end
                        ffba_pkg::OP_READ: begin
                            if (in_pool) begin
                                n_state = S_PRD;
                            end
                        end
                        ffba_pkg::OP_WRITE: begin
                            if (in_pool) begin
                                pl_we    = 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                if (st_rdata == '0) begin
                    n_state = S_RES;
                end else begin
                    // release the block's run
                    n_old    = st_rdata;
                    n_wstart = r_addr;
                    n_wlen   = st_rdata;
                    n_wzero  = 1'b1;
                    n_idx    = '0;
                    n_after  = (r_op == ffba_pkg::OP_FREE) ? AFT_OK : AFT_SRCH;
                    n_state  = S_WRUN;
                end
            end
            S_SRCH: begin
                if (r_idx < eff_n) begin
                    n_idx  = r_idx + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                end
                if (r_pv) begin
                    n_run = run_n;
                    if (run_n == r_size) begin
                        n_new    = AW'({1'b0, r_pidx} + 1'b1 - r_size);
                        n_wstart = AW'({1'b0, r_pidx} + 1'b1 - r_size);
                        n_wlen   = r_size;
                        n_wzero  = 1'b0;
                        n_idx    = '0;
                        n_pv     = 1'b0;
                        n_after  = (r_op == ffba_pkg::OP_ALLOC) ? AFT_OK : AFT_COPY;
                        n_res_start = AW'({1'b0, r_pidx} + 1'b1 - r_size);
                        n_state  = S_WRUN;
                    end
                end else if (r_idx >= eff_n) begin
                    if (r_op == ffba_pkg::OP_ALLOC) begin
                        n_state = S_RES;
                    end else begin
                        // restore the old block
                        n_wstart = r_addr;
                        n_wlen   = r_old;
                        n_wzero  = 1'b0;
                        n_idx    = '0;
                        n_after  = AFT_FAIL;
                        n_state  = S_WRUN;
                    end
                end
            end
            S_WRUN: begin
                st_we    = 1'b1;
                st_waddr = wsum[AW-1:0];
                st_wdata = r_wzero ? '0 : ((r_idx == '0) ? r_wlen : MW'(1));
                n_idx    = r_idx + 1'b1;
                if (wlast) begin
                    n_idx = '0;
                    n_run = '0;
                    case (r_after)
                        AFT_OK: begin
                            n_res_ok = 1'b1;
                            n_state  = S_RES;
                        end
                        AFT_SRCH: begin
                            n_state = S_SRCH;
                        end
                        AFT_COPY: begin
                            // copy downward when moving up, upward otherwise
                            n_desc  = (r_new > r_addr);
                            n_rem   = cnt;
                            n_idx   = (r_new > r_addr) ? (cnt - 1'b1) : '0;
                            n_state = S_CPRD;
                        end
                        default: begin
                            n_res_start = '0;
                            n_state     = S_RES;
                        end
                    endcase
                end
            end
            S_CPRD: begin
                pl_raddr = AW'({1'b0, r_addr} + r_idx);
                n_state  = S_CPWR;
            end
            S_CPWR: begin
                pl_we    = 1'b1;
                pl_waddr = AW'({1'b0, r_new} + r_idx);
                pl_wdata = pl_rdata;
                n_rem    = r_rem - 1'b1;
                n_idx    = r_desc ? (r_idx - 1'b1) : (r_idx + 1'b1);
                if (r_rem == MW'(1)) begin
                    n_res_ok = 1'b1;
                    n_state  = S_RES;
                end else begin
                    n_state = S_CPRD;
                end
            end
            S_PRD: begin
                n_res_ok    = 1'b1;
                n_res_rdata = pl_rdata;
                n_state     = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_pool_size <= DEPTH_V;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool_size <= i_cfg_pool_size;
            end
            // hand the pending result to the output register once it drains
            if (r_state == S_RES && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_size      <= n_size;
        r_addr      <= n_addr;
        r_old       <= n_old;
        r_pidx      <= n_pidx;
        r_run       <= n_run;
        r_wstart    <= n_wstart;
        r_wlen      <= n_wlen;
        r_wzero     <= n_wzero;
        r_after     <= n_after;
        r_new       <= n_new;
        r_desc      <= n_desc;
        r_rem       <= n_rem;
        r_res_ok    <= n_res_ok;
        r_res_start <= n_res_start;
        r_res_rdata <= n_res_rdata;
        if (r_state == S_RES && (!r_out_valid || i_out_ready)) begin
            r_ok    <= r_res_ok;
            r_start <= r_res_ok ? r_res_start : '0;
            r_rdata <= r_res_rdata;
        end
    end

endmodule
`default_nettype wire
